@@ rtl/armt_pkg.sv @@
`default_nettype none
package armt_pkg;

  localparam int TableEntriesDef = 32;

  // op codes
  localparam logic [2:0] OP_MAP    = 3'd0;
  localparam logic [2:0] OP_PROT   = 3'd1;
  localparam logic [2:0] OP_UNMAP  = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_NEXT   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_MISS    = 3'd4;

  // one stored range
  typedef struct packed {
    logic [31:0] space;
    logic [63:0] start;
    logic [63:0] stop;
    logic [63:0] mbase;
    logic [63:0] msize;
    logic [7:0]  perms;
    logic [31:0] flags;
    logic [63:0] img;
  } ent_t;

  localparam int EntW = $bits(ent_t);

  // which record goes to the shadow bank
  typedef enum logic [2:0] {
    PC_ENT,
    PC_LEFT,
    PC_MID,
    PC_RIGHT,
    PC_NEW
  } piece_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_RD,
    S_EV,
    S_DEC,
    S_NEWA,
    S_ENT,
    S_LEFT,
    S_MID,
    S_RIGHT,
    S_NEWZ,
    S_FIN
  } state_t;

  typedef struct packed {
    logic   load;
    logic   inc_idx;
    logic   capture_ent;
    logic   capture_fnd;
    logic   wr;
    piece_t piece;
    logic   finish;
  } cmd_t;

  typedef struct packed {
    logic is_map;
    logic is_prot;
    logic is_walk_lkp;
    logic skip;
    logic at_end;
    logic other;
    logic has_left;
    logic has_right;
    logic nb;
    logic ins;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/armt_ram.sv @@
`default_nettype none
module armt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/armt_ctrl.sv @@
`default_nettype none
module armt_ctrl
  import armt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.piece = PC_ENT;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = sts.skip ? S_FIN : S_RD;
      end
      S_RD: begin
        if (!sts.at_end) begin
          state_nxt = S_EV;
        end else if (sts.is_map && !sts.ins) begin
          state_nxt = S_NEWZ;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EV: begin
        cmd.capture_ent = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (sts.is_walk_lkp) begin
          cmd.capture_fnd = 1'b1;
          cmd.inc_idx = 1'b1;
          state_nxt = S_RD;
        end else if (sts.other) begin
          state_nxt = (sts.is_map && !sts.ins && sts.nb) ? S_NEWA : S_ENT;
        end else if (sts.has_left) begin
          state_nxt = S_LEFT;
        end else if (sts.is_prot) begin
          state_nxt = S_MID;
        end else if (sts.has_right) begin
          state_nxt = (sts.is_map && !sts.ins) ? S_NEWA : S_RIGHT;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_NEWA: begin
        cmd.wr = 1'b1;
        cmd.piece = PC_NEW;
        state_nxt = sts.other ? S_ENT : S_RIGHT;
      end
      S_ENT: begin
        cmd.wr = 1'b1;
        cmd.piece = PC_ENT;
        cmd.inc_idx = 1'b1;
        state_nxt = S_RD;
      end
      S_LEFT: begin
        cmd.wr = 1'b1;
        cmd.piece = PC_LEFT;
        if (sts.is_prot) begin
          state_nxt = S_MID;
        end else if (sts.has_right) begin
          state_nxt = (sts.is_map && !sts.ins) ? S_NEWA : S_RIGHT;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_MID: begin
        cmd.wr = 1'b1;
        cmd.piece = PC_MID;
        if (sts.has_right) begin
          state_nxt = S_RIGHT;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RIGHT: begin
        cmd.wr = 1'b1;
        cmd.piece = PC_RIGHT;
        cmd.inc_idx = 1'b1;
        state_nxt = S_RD;
      end
      S_NEWZ: begin
        cmd.wr = 1'b1;
        cmd.piece = PC_NEW;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/armt_dp.sv @@
`default_nettype none
module armt_dp
  import armt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_space_id,
  input  wire logic [63:0] in_base_address,
  input  wire logic [63:0] in_length,
  input  wire logic [7:0]  in_new_perms,
  input  wire logic [31:0] in_new_flags,
  input  wire logic [63:0] in_new_image_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_hit,
  output logic [63:0]      out_range_start,
  output logic [63:0]      out_range_end,
  output logic [63:0]      out_mapping_base,
  output logic [63:0]      out_mapping_size,
  output logic [7:0]       out_found_perms,
  output logic [31:0]      out_found_flags,
  output logic [63:0]      out_found_image_offset,
  output logic [63:0]      out_offset_in_mapping
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int DEPTH = 2 << IW;
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  // request registers
  logic [2:0]  op_r;
  logic [31:0] sp_r;
  logic [63:0] base_r, len_r, stop_r, img_r;
  logic [7:0]  perms_r;
  logic [31:0] flags_r;

  // table control
  logic          bank_r;
  logic [CW-1:0] cnt_r, idx_r, wcnt_r;
  logic          over_r, ins_r;

  // walk registers
  ent_t ent_r, fnd_r;
  logic any_r;
  logic sp_eq_r, other_r, left_r, right_r, nb_r;

  // output registers
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic        hit_r;
  ent_t        res_r;
  logic [63:0] offs_r;

  ent_t        rdata, wdata;
  logic        we;
  logic [64:0] sum;
  logic        len0, bad;
  logic        is_map, is_prot, is_upd, is_lkp, is_nxt;
  logic        lk_hit, nx_hit;
  logic [2:0]  res_status;

  assign sum    = {1'b0, in_base_address} + {1'b0, in_length};
  assign len0   = (len_r == '0);
  assign bad    = (stop_r <= base_r);
  assign is_map  = (op_r == OP_MAP);
  assign is_prot = (op_r == OP_PROT);
  assign is_upd  = is_map || is_prot || (op_r == OP_UNMAP);
  assign is_lkp  = (op_r == OP_LOOKUP);
  assign is_nxt  = (op_r == OP_NEXT);

  // ping-pong table banks in one memory
  armt_ram #(.WIDTH(EntW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr ({~bank_r, wcnt_r[IW-1:0]}),
    .wdata (wdata),
    .raddr ({bank_r, idx_r[IW-1:0]}),
    .rdata (rdata)
  );

  assign we = cmd.wr && (wcnt_r != FULL_CNT);

  // record for the shadow bank
  always_comb begin
    wdata = ent_r;
    unique case (cmd.piece)
      PC_ENT: wdata = ent_r;
      PC_LEFT: wdata.stop = base_r;
      PC_MID: begin
        wdata.start = (ent_r.start > base_r) ? ent_r.start : base_r;
        wdata.stop  = (ent_r.stop < stop_r) ? ent_r.stop : stop_r;
        wdata.perms = perms_r;
        wdata.flags = flags_r;
      end
      PC_RIGHT: wdata.start = stop_r;
      PC_NEW: begin
        wdata.space = sp_r;
        wdata.start = base_r;
        wdata.stop  = stop_r;
        wdata.mbase = base_r;
        wdata.msize = len_r;
        wdata.perms = perms_r;
        wdata.flags = flags_r;
        wdata.img   = img_r;
      end
      default: wdata = ent_r;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      sp_r    <= in_space_id;
      base_r  <= in_base_address;
      len_r   <= in_length;
      stop_r  <= sum[64] ? '1 : sum[63:0];
      perms_r <= in_new_perms;
      flags_r <= in_new_flags;
      img_r   <= in_new_image_offset;
    end
  end

  // entry capture and overlap classification
  always_ff @(posedge clk) begin
    if (cmd.capture_ent) begin
      ent_r   <= rdata;
      sp_eq_r <= (rdata.space == sp_r);
      other_r <= (rdata.space != sp_r) || (rdata.stop <= base_r) || (rdata.start >= stop_r);
      left_r  <= (rdata.start < base_r);
      right_r <= (rdata.stop > stop_r);
      nb_r    <= (sp_r < rdata.space) || ((rdata.space == sp_r) && (base_r < rdata.start));
    end
  end

  // search capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else if (cmd.load) begin
      any_r <= 1'b0;
    end else if (cmd.capture_fnd) begin
      if (is_lkp && sp_eq_r && (ent_r.start <= base_r)) begin
        any_r <= 1'b1;
      end else if (is_nxt && sp_eq_r && (ent_r.start >= base_r) && !any_r) begin
        any_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_fnd) begin
      if (is_lkp && sp_eq_r && (ent_r.start <= base_r)) begin
        fnd_r <= ent_r;
      end else if (is_nxt && sp_eq_r && (ent_r.start >= base_r) && !any_r) begin
        fnd_r <= ent_r;
      end
    end
  end

  // walk and write counters, bank select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      cnt_r  <= '0;
      idx_r  <= '0;
      wcnt_r <= '0;
      over_r <= 1'b0;
      ins_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r  <= '0;
        wcnt_r <= '0;
        over_r <= 1'b0;
        ins_r  <= 1'b0;
      end else begin
        if (cmd.inc_idx) begin
          idx_r <= idx_r + 1'b1;
        end
        if (cmd.wr) begin
          if (wcnt_r == FULL_CNT) begin
            over_r <= 1'b1;
          end else begin
            wcnt_r <= wcnt_r + 1'b1;
          end
          if (cmd.piece == PC_NEW) begin
            ins_r <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        if (op_r == OP_CLEAR) begin
          cnt_r <= '0;
        end else if (is_upd && !len0 && !bad && !over_r) begin
          bank_r <= ~bank_r;
          cnt_r  <= wcnt_r;
        end
      end
    end
  end

  // result evaluation
  assign lk_hit = is_lkp && !len0 && !bad && any_r && (base_r < fnd_r.stop)
                  && (stop_r <= fnd_r.stop) && (base_r >= fnd_r.mbase);
  assign nx_hit = is_nxt && any_r;

  always_comb begin
    res_status = ST_UNKNOWN;
    priority if (is_upd) begin
      res_status = len0 ? ST_OK : (bad ? ST_INVALID : (over_r ? ST_FULL : ST_OK));
    end else if (is_lkp) begin
      res_status = lk_hit ? ST_OK : ST_MISS;
    end else if (is_nxt) begin
      res_status = nx_hit ? ST_OK : ST_MISS;
    end else if (op_r == OP_CLEAR) begin
      res_status = ST_OK;
    end else begin
      res_status = ST_UNKNOWN;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r <= res_status;
      hit_r    <= lk_hit || nx_hit;
      res_r    <= (lk_hit || nx_hit) ? fnd_r : '0;
      offs_r   <= lk_hit ? (base_r - fnd_r.mbase) : '0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_hit                = hit_r;
  assign out_range_start        = res_r.start;
  assign out_range_end          = res_r.stop;
  assign out_mapping_base       = res_r.mbase;
  assign out_mapping_size       = res_r.msize;
  assign out_found_perms        = res_r.perms;
  assign out_found_flags        = res_r.flags;
  assign out_found_image_offset = res_r.img;
  assign out_offset_in_mapping  = offs_r;

  // status to the controller
  always_comb begin
    sts.is_map      = is_map;
    sts.is_prot     = is_prot;
    sts.is_walk_lkp = is_lkp || is_nxt;
    sts.skip        = !(is_upd || is_lkp || is_nxt) || ((is_upd || is_lkp) && (len0 || bad));
    sts.at_end      = (idx_r == cnt_r);
    sts.other       = other_r;
    sts.has_left    = left_r;
    sts.has_right   = right_r;
    sts.nb          = nb_r;
    sts.ins         = ins_r;
    sts.out_free    = !out_valid_r || !out_stall;
  end

endmodule
`default_nettype wire

@@ rtl/address_range_map_table_unit.sv @@
// Address range map table.
// Input channel (in_valid/in_stall) carries one request item: map, protect,
// unmap, lookup, next_after or clear. The result channel (out_valid/out_stall)
// returns exactly one result item per request, in order.
// One item is worked on at a time; in_stall is high from acceptance until the
// result is loaded into the output register.
// Clear, unknown ops, zero length and invalid updates, and zero length or
// invalid lookups skip the table walk and go straight to the result.
// Lookup and next_after walk every stored range.
// Updates walk every stored range and write each range record to the shadow
// bank (none to three per stored range, plus one for the new range of a map).
// The walk reads, captures and classifies each entry, then writes its records,
// from a single ping-pong table memory; an update rebuilds the other bank and
// swaps banks on success.
// Reset empties the table at once (the entry count is cleared), no sweep.
// A stalled result holds in the output register; the next item is still
// accepted and waits in its final cycle until the output register is free.
`default_nettype none
module address_range_map_table_unit
  import armt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_space_id,
  input  wire logic [63:0] in_base_address,
  input  wire logic [63:0] in_length,
  input  wire logic [7:0]  in_new_perms,
  input  wire logic [31:0] in_new_flags,
  input  wire logic [63:0] in_new_image_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_hit,
  output logic [63:0]      out_range_start,
  output logic [63:0]      out_range_end,
  output logic [63:0]      out_mapping_base,
  output logic [63:0]      out_mapping_size,
  output logic [7:0]       out_found_perms,
  output logic [31:0]      out_found_flags,
  output logic [63:0]      out_found_image_offset,
  output logic [63:0]      out_offset_in_mapping
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  armt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, walk and result datapath
  armt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_op                  (in_op),
    .in_space_id            (in_space_id),
    .in_base_address        (in_base_address),
    .in_length              (in_length),
    .in_new_perms           (in_new_perms),
    .in_new_flags           (in_new_flags),
    .in_new_image_offset    (in_new_image_offset),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_hit                (out_hit),
    .out_range_start        (out_range_start),
    .out_range_end          (out_range_end),
    .out_mapping_base       (out_mapping_base),
    .out_mapping_size       (out_mapping_size),
    .out_found_perms        (out_found_perms),
    .out_found_flags        (out_found_flags),
    .out_found_image_offset (out_found_image_offset),
    .out_offset_in_mapping  (out_offset_in_mapping)
  );

endmodule
`default_nettype wire

@@ rtl/armt_chk.sv @@
`default_nettype none
module armt_chk
  import armt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic        out_hit,
  input wire logic [63:0] out_range_start,
  input wire logic [63:0] out_range_end,
  input wire logic [63:0] out_offset_in_mapping
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // one item at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // a hit always reports ok
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_OK)
    else $error("hit with non-ok status");

  // a found range is never empty
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_range_start < out_range_end)
    else $error("hit on empty range");

  // a miss carries zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_range_end == '0 && out_offset_in_mapping == '0)
    else $error("miss with nonzero payload");

endmodule

bind address_range_map_table_unit armt_chk u_chk (.*);
`default_nettype wire
